@@ design/tpt_pkg.sv @@
package tpt_pkg;

    // Counter and field widths
    localparam int CntW  = 16;
    localparam int PerW  = CntW + 1;
    localparam int TpsW  = 30;
    localparam int UsW   = 32;
    localparam int IntW  = 16;
    localparam int TotW  = 64;
    localparam int ProdW = TpsW + UsW;

    // Microsecond to tick conversion: ticks = (tps * us) / 1e6.
    // Only quotients below 2^IntW matter (longer wakeups are always ignored),
    // so divide the low part of the product as (p >> 6) / 15625.
    localparam longint unsigned BigLimit = (64'd1 << IntW) * 64'd1000000;
    localparam int SmallW     = $clog2(BigLimit);
    localparam int ScaleShift = 6;
    localparam int XW         = SmallW - ScaleShift;
    localparam int DivConst   = 15625;
    localparam int RecipShift = 44;
    localparam int RecipW     = 31;
    localparam logic [RecipW-1:0] RecipM = RecipW'((64'd1 << RecipShift) / DivConst);
    localparam int QProdW     = XW + RecipW;

    // Items in flight: four conversion stages plus the output register
    localparam int PipeDepth = 5;
    localparam int OutstW    = $clog2(PipeDepth + 1);

    // Request codes
    localparam logic [1:0] ReqTick = 2'd0;
    localparam logic [1:0] ReqRead = 2'd1;
    localparam logic [1:0] ReqWake = 2'd2;

    // Register indexes
    localparam logic [1:0] CfgTps      = 2'd0;
    localparam logic [1:0] CfgInterval = 2'd1;
    localparam logic [1:0] CfgMinWake  = 2'd2;

    // Register reset values
    localparam logic [TpsW-1:0] TpsReset      = TpsW'(1000000);
    localparam logic [IntW-1:0] IntervalReset = IntW'(1000);
    localparam logic [IntW-1:0] MinWakeReset  = IntW'(10);

    typedef struct packed {
        logic [TpsW-1:0] tps;
        logic [IntW-1:0] interval;
        logic [IntW-1:0] min_wake;
    } cfg_t;

    typedef struct packed {
        logic            valid;
        logic [1:0]      req;
        logic            big;
        logic [IntW-1:0] wake;
    } wake_t;

endpackage

@@ design/tickless_period_timer.sv @@
// Throughput: one word per cycle while the output is not stalled, set by the
// four-stage microsecond-to-tick multiply and correct pipeline feeding the
// timer state register; a result passes those stages, then the output register.
// Reset: counter and tick accumulator clear, interval 1000, reload 999, rate 1 MHz,
// minimum wakeup 10; all pipeline stages and the output come up empty.
module tickless_period_timer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                req_type,
    input  logic [tpt_pkg::UsW-1:0]   wait_us,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [tpt_pkg::TotW-1:0]  tick_total,
    output logic                      update_pulse,
    output logic                      wakeup_applied,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [tpt_pkg::TpsW-1:0]  cfg_data
);
    import tpt_pkg::*;

    logic [TpsW-1:0] tps_reg;
    logic [IntW-1:0] interval_reg;
    logic [IntW-1:0] min_wake_reg;
    cfg_t            cfg;
    wake_t           wake_item;
    logic            core_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg      <= TpsReset;
            interval_reg <= IntervalReset;
            min_wake_reg <= MinWakeReset;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CfgTps:      tps_reg      <= cfg_data;
                CfgInterval: interval_reg <= cfg_data[IntW-1:0];
                CfgMinWake:  min_wake_reg <= cfg_data[IntW-1:0];
                default:     ;
            endcase
        end
    end

    assign cfg.tps      = tps_reg;
    assign cfg.interval = interval_reg;
    assign cfg.min_wake = min_wake_reg;

    tpt_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .wait_us    (wait_us),
        .cfg        (cfg),
        .wake_item  (wake_item),
        .down_ready (core_ready)
    );

    tpt_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (wake_item),
        .item_ready     (core_ready),
        .cfg            (cfg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tick_total     (tick_total),
        .update_pulse   (update_pulse),
        .wakeup_applied (wakeup_applied)
    );

endmodule

@@ design/tpt_convert.sv @@
module tpt_convert (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             req_type,
    input  logic [tpt_pkg::UsW-1:0] wait_us,
    input  tpt_pkg::cfg_t          cfg,
    output tpt_pkg::wake_t         wake_item,
    input  logic                   down_ready
);
    import tpt_pkg::*;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic rdy0, rdy1, rdy2, rdy3;

    logic [1:0]       req0_reg, req1_reg, req2_reg, req3_reg;
    logic [UsW-1:0]   us0_reg;
    logic [ProdW-1:0] prod1_reg;
    logic             big2_reg, big3_reg;
    logic [IntW-1:0]  q2_reg, wake3_reg;
    logic [XW-1:0]    x2_reg;

    logic              big2_next;
    logic [XW-1:0]     x2_next;
    logic [QProdW-1:0] qprod;
    logic [IntW-1:0]   q2_next;
    logic [XW-1:0]     qmul;
    logic [XW-1:0]     rem;
    logic [IntW-1:0]   q3;
    logic [IntW-1:0]   wake3_next;

    // A stage takes a word when it is empty or its word moves on
    assign rdy3     = !v3_reg || down_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    // Estimate the quotient by reciprocal; it is exact or one low
    assign big2_next = prod1_reg >= ProdW'(BigLimit);
    assign x2_next   = prod1_reg[SmallW-1:ScaleShift];
    assign qprod     = QProdW'(x2_next) * QProdW'(RecipM);
    assign q2_next   = qprod[RecipShift +: IntW];

    // Correct the estimate, then raise to the minimum
    assign qmul       = XW'(q2_reg) * XW'(DivConst);
    assign rem        = x2_reg - qmul;
    assign q3         = q2_reg + IntW'(rem >= XW'(DivConst));
    assign wake3_next = (q3 < cfg.min_wake) ? cfg.min_wake : q3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= in_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
        begin
            req0_reg <= req_type;
            us0_reg  <= wait_us;
        end
        if (rdy1 && v0_reg)
        begin
            req1_reg  <= req0_reg;
            prod1_reg <= ProdW'(cfg.tps) * ProdW'(us0_reg);
        end
        if (rdy2 && v1_reg)
        begin
            req2_reg <= req1_reg;
            big2_reg <= big2_next;
            x2_reg   <= x2_next;
            q2_reg   <= q2_next;
        end
        if (rdy3 && v2_reg)
        begin
            req3_reg  <= req2_reg;
            big3_reg  <= big2_reg;
            wake3_reg <= wake3_next;
        end
    end

    assign wake_item.valid = v3_reg;
    assign wake_item.req   = req3_reg;
    assign wake_item.big   = big3_reg;
    assign wake_item.wake  = wake3_reg;

endmodule

@@ design/tpt_core.sv @@
module tpt_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tpt_pkg::wake_t          item,
    output logic                    item_ready,
    input  tpt_pkg::cfg_t           cfg,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [tpt_pkg::TotW-1:0] tick_total,
    output logic                    update_pulse,
    output logic                    wakeup_applied
);
    import tpt_pkg::*;

    logic [CntW-1:0] counter_reg, counter_next;
    logic [CntW-1:0] reload_reg, reload_next;
    logic [PerW-1:0] period_reg, period_next;
    logic [TotW-1:0] acc_reg, acc_next;
    logic            out_valid_reg;
    logic [TotW-1:0] total_reg;
    logic            pulse_reg, applied_reg;

    logic                 take;
    logic                 is_tick, is_wake, end_period, apply;
    logic [PerW-1:0]      target;
    logic [PerW-1:0]      addend;
    logic [TotW-1:0]      sum;
    logic [CntW+IntW-1:0] interval_m1;

    assign item_ready = !out_valid_reg || out_ready;
    assign take       = item.valid && item_ready;

    assign is_tick     = item.req == ReqTick;
    assign is_wake     = item.req == ReqWake;
    assign end_period  = is_tick && (counter_reg >= reload_reg);
    assign target      = PerW'(counter_reg) + PerW'(item.wake);
    assign apply       = is_wake && !item.big && (item.wake < cfg.interval)
                         && (target < PerW'(reload_reg));
    assign interval_m1 = {{CntW{1'b0}}, cfg.interval} - (CntW+IntW)'(1);

    always_comb
    begin
        counter_next = counter_reg;
        reload_next  = reload_reg;
        period_next  = period_reg;
        addend       = PerW'(counter_reg);
        if (end_period)
        begin
            counter_next = '0;
            reload_next  = interval_m1[CntW-1:0];
            period_next  = PerW'(cfg.interval);
            addend       = period_reg;
        end
        else if (is_tick)
        begin
            counter_next = counter_reg + CntW'(1);
            addend       = PerW'(counter_reg) + PerW'(1);
        end
        if (apply)
        begin
            reload_next = target[CntW-1:0];
            period_next = target + PerW'(1);
        end
    end

    // One adder serves both the period fold and the reported total
    assign sum      = acc_reg + TotW'(addend);
    assign acc_next = end_period ? sum : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            reload_reg    <= CntW'(IntervalReset - IntW'(1));
            period_reg    <= PerW'(IntervalReset);
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            counter_reg   <= counter_next;
            reload_reg    <= reload_next;
            period_reg    <= period_next;
            acc_reg       <= acc_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            total_reg   <= sum;
            pulse_reg   <= end_period;
            applied_reg <= apply;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tick_total     = total_reg;
    assign update_pulse   = pulse_reg;
    assign wakeup_applied = applied_reg;

endmodule

@@ design/tpt_checker.sv @@
module tpt_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [tpt_pkg::TotW-1:0]  tick_total,
    input logic                      update_pulse,
    input logic                      wakeup_applied
);
    import tpt_pkg::*;

    logic [OutstW-1:0] outst_reg, outst_next;
    logic              in_acc, out_acc;

    assign in_acc     = in_valid && in_ready;
    assign out_acc    = out_valid && out_ready;
    assign outst_next = outst_reg + OutstW'(in_acc) - OutstW'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outst_reg <= '0;
        else
            outst_reg <= outst_next;
    end

    // A held result keeps its word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tick_total)
            && $stable(update_pulse) && $stable(wakeup_applied))
        else $error("result changed while stalled");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(update_pulse && wakeup_applied))
        else $error("period end and wakeup on one word");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outst_reg != '0)
        else $error("result with no request in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        outst_reg <= OutstW'(PipeDepth))
        else $error("more words in flight than stages");

endmodule

bind tickless_period_timer tpt_checker u_tpt_checker (.*);
